// File: sv/assert_macros.svh
// Assertion macros used by the grid core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: sv/mdg_pkg.sv
// Package: constants, codes and shared types of the midpoint displacement grid.
`default_nettype none
package mdg_pkg;
   localparam int LOG_SIZE_DEF    = 4;
   localparam int STACK_DEPTH_DEF = 6;

   localparam int SAMPLE_W    = 16;
   localparam int IVAR_W      = 31;
   localparam int DECAY_W     = 16;
   localparam int VAR_W       = 32;
   localparam int HEIGHT_W    = 32;
   localparam int COORD_OUT_W = 4;
   localparam int VAR_SHIFT   = 9;   // the factor 512 of the child variance
   localparam int V_W         = 40;  // working width of a signed height value

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 31;

   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_VARIANCE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VARIANCE_DECAY   = 1'd1;

   localparam logic [IVAR_W-1:0]  IVAR_RESET  = 31'd1048576;
   localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd512;

   // write phases of one rectangle
   localparam logic [2:0] PH_TOP    = 3'd0;
   localparam logic [2:0] PH_BOTTOM = 3'd1;
   localparam logic [2:0] PH_LEFT   = 3'd2;
   localparam logic [2:0] PH_RIGHT  = 3'd3;
   localparam logic [2:0] PH_CENTRE = 3'd4;

   // sub-rectangle order
   localparam logic [1:0] CHILD_TL = 2'd0;
   localparam logic [1:0] CHILD_TR = 2'd1;
   localparam logic [1:0] CHILD_BL = 2'd2;
   localparam logic [1:0] CHILD_BR = 2'd3;

   localparam int RD_CNT_W = 4;
   localparam logic [RD_CNT_W-1:0] N_EDGE_RD = 4'd2;
   localparam logic [RD_CNT_W-1:0] N_CTR_RD  = 4'd8;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;
endpackage
`default_nettype wire

// File: sv/mdg_if.sv
// Request and response channel interfaces of the grid core.
`default_nettype none
interface mdg_req_if;
   import mdg_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] rand_sample;
   modport source (output valid, output rand_sample, input ready);
   modport sink   (input valid, input rand_sample, output ready);
endinterface

interface mdg_rsp_if;
   import mdg_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [COORD_OUT_W-1:0] cell_row;
   logic [COORD_OUT_W-1:0] cell_col;
   logic [HEIGHT_W-1:0]    cell_height;
   logic                   done_res;
   modport source (output valid, output cell_row, output cell_col, output cell_height,
                   output done_res, input ready);
   modport sink   (input valid, input cell_row, input cell_col, input cell_height,
                   input done_res, output ready);
endinterface
`default_nettype wire

// File: sv/mdg_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module mdg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: sv/mdg_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module mdg_div #(
   parameter int DIV_W = 45,
   parameter int DVS_W = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_W-1:0]     dividend,
   input  logic [DVS_W-1:0]     divisor,
   output logic [DIV_W-1:0]     quotient,
   output mdg_pkg::div_sts_type sts
);
   import mdg_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [DVS_W:0]   rem_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W:0]   rem_sh;
   logic [DVS_W:0]   rem_nx;
   logic             ge;

   always_comb begin
      rem_sh = {rem_ff[DVS_W-1:0], quo_ff[DIV_W-1]};
      ge     = rem_sh >= {1'b0, dvs_ff};
      rem_nx = ge ? rem_sh - {1'b0, dvs_ff} : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[DIV_W-2:0], ge};
            rem_ff <= rem_nx;
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient = quo_ff;
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
endmodule
`default_nettype wire

// File: sv/midpoint_displacement_grid_core.sv
// Top level: midpoint displacement height grid built one sample at a time.
// A corner item is written directly; an edge item skips each already written edge cell and
// adds a bit-serial correction divide when the span is even.
// A centre item adds the same correction, then pops finished frames and may push a child
// whose variance comes from the same divider. One item at a time.
// Reset (synchronous, active high) clears flags, stack depth, counters, registers to defaults.
`default_nettype none
`include "assert_macros.svh"
module midpoint_displacement_grid_core #(
   parameter int LOG_SIZE    = mdg_pkg::LOG_SIZE_DEF,
   parameter int STACK_DEPTH = mdg_pkg::STACK_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   mdg_req_if.sink                         req,
   mdg_rsp_if.source                       rsp,
   input  logic                            csr_wr_en,
   input  logic [mdg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mdg_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import mdg_pkg::*;

   localparam int CW     = LOG_SIZE;
   localparam int CELL_W = 2 * LOG_SIZE;
   localparam int CELLS  = 1 << CELL_W;
   localparam int SD_W   = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W  = $clog2(STACK_DEPTH);
   localparam int DIV_W  = VAR_W + CW + VAR_SHIFT;
   localparam int DVS_W  = CW + DECAY_W;

   typedef struct packed {
      logic [CW-1:0]    c1;
      logic [CW-1:0]    c2;
      logic [CW-1:0]    c3;
      logic [CW-1:0]    c4;
      logic [VAR_W-1:0] variance;
      logic [1:0]       child;
   } frame_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CORNER, S_SCAN, S_OFF, S_READ, S_AVG, S_SKEW, S_WRITE,
      S_ADV, S_POP, S_PMUL, S_PDIV, S_PWAIT, S_OUT
   } state_type;

   // configuration
   logic [IVAR_W-1:0]  ivar_ff;
   logic [DECAY_W-1:0] decay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ivar_ff  <= IVAR_RESET;
         decay_ff <= DECAY_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_INITIAL_VARIANCE: ivar_ff  <= csr_wr_data[IVAR_W-1:0];
            REG_VARIANCE_DECAY:   decay_ff <= csr_wr_data[DECAY_W-1:0];
         endcase
      end
   end

   state_type              state_ff;
   logic [2:0]             corner_ff;
   logic [SD_W-1:0]        depth_ff;
   logic [2:0]             phase_ff;
   logic [CELLS-1:0]       flags_ff;
   frame_type              stack_ff [STACK_DEPTH];
   logic [SAMPLE_W-1:0]    sample_ff;
   logic [2:0]             kind_ff;
   logic [CW-1:0]          tgt_r_ff, tgt_c_ff, d_ff;
   logic signed [V_W-1:0]  off_ff, sum_ff, v_ff;
   logic [HEIGHT_W-1:0]    ha_ff;
   logic [RD_CNT_W-1:0]    cnt_ff;
   logic                   neg_ff;
   logic [1:0]             push_k_ff;
   logic [VAR_W+CW-1:0]    num_ff;
   logic [DVS_W-1:0]       den_ff;
   logic [COORD_OUT_W-1:0] res_row_ff, res_col_ff;
   logic [HEIGHT_W-1:0]    res_h_ff;
   logic                   res_done_ff;
   logic                   rsp_valid_ff;
   logic [COORD_OUT_W-1:0] out_row_ff, out_col_ff;
   logic [HEIGHT_W-1:0]    out_h_ff;
   logic                   out_done_ff;

   // top of stack and its split points
   logic [SD_W-1:0] depth_m1;
   frame_type       top;
   logic [CW-1:0]   lo, la;
   logic            skew, leaf;

   always_comb begin
      depth_m1 = depth_ff - SD_W'(1);
      top      = stack_ff[depth_m1[IDX_W-1:0]];
      lo       = CW'(({1'b0, top.c1} + {1'b0, top.c3}) >> 1);
      la       = CW'(({1'b0, top.c2} + {1'b0, top.c4}) >> 1);
      skew     = top.c1[0] == top.c3[0];
      leaf     = (lo == top.c1) || (lo == top.c3) || (la == top.c2) || (la == top.c4);
   end

   // edge cell checked in the current write phase
   logic [CW-1:0] scan_r, scan_c, scan_d;

   always_comb begin
      scan_r = la;
      scan_c = top.c1;
      scan_d = la - top.c2;
      if (phase_ff == PH_TOP) begin
         scan_r = top.c2;
         scan_c = lo;
         scan_d = lo - top.c1;
      end else if (phase_ff == PH_BOTTOM) begin
         scan_r = top.c4;
         scan_c = lo;
         scan_d = lo - top.c1;
      end else if (phase_ff == PH_RIGHT) begin
         scan_c = top.c3;
      end
   end

   // height reads; the first read is always the skew anchor
   logic [CW-1:0] rd_r, rd_c;

   always_comb begin
      rd_r = top.c2;
      rd_c = top.c1;
      if (kind_ff == PH_CENTRE) begin
         unique case (cnt_ff[2:0])
            3'd0: begin rd_r = top.c2; rd_c = top.c1; end
            3'd1: begin rd_r = top.c2; rd_c = top.c3; end
            3'd2: begin rd_r = top.c4; rd_c = top.c1; end
            3'd3: begin rd_r = top.c4; rd_c = top.c3; end
            3'd4: begin rd_r = top.c2; rd_c = lo;     end
            3'd5: begin rd_r = top.c4; rd_c = lo;     end
            3'd6: begin rd_r = la;     rd_c = top.c1; end
            3'd7: begin rd_r = la;     rd_c = top.c3; end
         endcase
      end else if (kind_ff == PH_TOP) begin
         rd_r = top.c2;
         rd_c = (cnt_ff == '0) ? top.c1 : top.c3;
      end else if (kind_ff == PH_BOTTOM) begin
         rd_r = top.c4;
         rd_c = (cnt_ff == '0) ? top.c1 : top.c3;
      end else if (kind_ff == PH_LEFT) begin
         rd_r = (cnt_ff == '0) ? top.c2 : top.c4;
         rd_c = top.c1;
      end else begin
         rd_r = (cnt_ff == '0) ? top.c2 : top.c4;
         rd_c = top.c3;
      end
   end

   logic [RD_CNT_W-1:0] n_reads;
   assign n_reads = (kind_ff == PH_CENTRE) ? N_CTR_RD : N_EDGE_RD;

   // arithmetic
   logic [SAMPLE_W+VAR_W-1:0] prod;
   logic [VAR_W-1:0]          cur_var;
   logic [HEIGHT_W-1:0]       corner_h;
   logic signed [V_W-1:0]     off_c, sum_rnd, avg, v_c, diff, qs;
   logic [V_W-1:0]            mag;
   logic [HEIGHT_W-1:0]       sat_v;
   logic [CW-1:0]             corner_r, corner_c;
   localparam logic signed [V_W-1:0] HMAX = V_W'(signed'(32'h7FFF_FFFF));
   localparam logic signed [V_W-1:0] HMIN = V_W'(signed'(32'h8000_0000));

   always_comb begin
      cur_var  = (state_ff == S_CORNER) ? VAR_W'(ivar_ff) : top.variance;
      prod     = SAMPLE_W'(sample_ff) * cur_var;
      corner_h = HEIGHT_W'(prod >> SAMPLE_W);
      off_c    = V_W'(prod[SAMPLE_W+VAR_W-1:SAMPLE_W]) - V_W'(top.variance >> 1);
      // truncation toward zero for the /2 and /8 averages
      sum_rnd  = sum_ff + signed'({{(V_W-3){1'b0}},
                 (kind_ff == PH_CENTRE) ? {3{sum_ff[V_W-1]}} : {2'b00, sum_ff[V_W-1]}});
      avg      = (kind_ff == PH_CENTRE) ? (sum_rnd >>> 3) : (sum_rnd >>> 1);
      v_c      = avg + off_ff;
      diff     = V_W'(signed'(ha_ff)) - v_c;
      mag      = diff[V_W-1] ? V_W'(-diff) : V_W'(diff);
      if (v_ff > HMAX) begin
         sat_v = 32'h7FFF_FFFF;
      end else if (v_ff < HMIN) begin
         sat_v = 32'h8000_0000;
      end else begin
         sat_v = v_ff[HEIGHT_W-1:0];
      end
      corner_r = (corner_ff >= 3'd2) ? '1 : '0;
      corner_c = (corner_ff == 3'd1 || corner_ff == 3'd2) ? '1 : '0;
   end

   // child frame being pushed
   frame_type          child_f;
   logic [CW-1:0]      part, span;
   logic [DECAY_W-1:0] dec_eff;

   always_comb begin
      child_f          = top;
      child_f.child    = CHILD_TL;
      part             = lo - top.c1;
      span             = top.c3 - top.c1;
      unique case (push_k_ff)
         CHILD_TL: begin
            child_f.c3 = lo;  child_f.c4 = la;
         end
         CHILD_TR: begin
            child_f.c1 = lo;  child_f.c4 = la;
            part       = top.c3 - lo;
         end
         CHILD_BL: begin
            child_f.c2 = la;  child_f.c3 = lo;
            part       = la - top.c2;
            span       = top.c4 - top.c2;
         end
         CHILD_BR: begin
            child_f.c1 = lo;  child_f.c2 = la;
            part       = top.c4 - la;
            span       = top.c4 - top.c2;
         end
      endcase
      dec_eff = (decay_ff == '0) ? DECAY_W'(1) : decay_ff;
   end

   // shared divider
   logic             div_start;
   logic [DIV_W-1:0] div_dividend, div_quo;
   logic [DVS_W-1:0] div_divisor;
   div_sts_type      div_sts;

   always_comb begin
      div_start    = (state_ff == S_AVG && skew) || (state_ff == S_PDIV);
      div_dividend = (state_ff == S_PDIV) ? {num_ff, VAR_SHIFT'(0)} : DIV_W'(mag);
      div_divisor  = (state_ff == S_PDIV) ? den_ff : DVS_W'({d_ff, 1'b1});
      qs           = V_W'(div_quo);
   end

   mdg_div #(.DIV_W(DIV_W), .DVS_W(DVS_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .sts      (div_sts)
   );

   // height store
   logic                ram_we;
   logic [CELL_W-1:0]   ram_waddr;
   logic [HEIGHT_W-1:0] ram_wdata, ram_rdata;

   always_comb begin
      ram_we    = (state_ff == S_CORNER) || (state_ff == S_WRITE);
      ram_waddr = (state_ff == S_CORNER) ? {corner_r, corner_c} : {tgt_r_ff, tgt_c_ff};
      ram_wdata = (state_ff == S_CORNER) ? corner_h : sat_v;
   end

   mdg_ram #(.WIDTH(HEIGHT_W), .DEPTH(CELLS)) u_height (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr ({rd_r, rd_c}),
      .rd_data (ram_rdata)
   );

   logic out_free;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         corner_ff    <= '0;
         depth_ff     <= '0;
         phase_ff     <= PH_TOP;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
            out_row_ff   <= res_row_ff;
            out_col_ff   <= res_col_ff;
            out_h_ff     <= res_h_ff;
            out_done_ff  <= res_done_ff;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  sample_ff <= req.rand_sample;
                  state_ff  <= (corner_ff < 3'd4) ? S_CORNER : S_SCAN;
               end
            end
            S_CORNER: begin
               flags_ff[{corner_r, corner_c}] <= 1'b1;
               res_row_ff  <= COORD_OUT_W'(corner_r);
               res_col_ff  <= COORD_OUT_W'(corner_c);
               res_h_ff    <= corner_h;
               res_done_ff <= 1'b0;
               corner_ff   <= corner_ff + 3'd1;
               if (corner_ff == 3'd3) begin
                  depth_ff    <= SD_W'(1);
                  phase_ff    <= PH_TOP;
                  stack_ff[0] <= '{c1: '0, c2: '0, c3: '1, c4: '1,
                                   variance: VAR_W'(ivar_ff), child: CHILD_TL};
               end
               state_ff <= S_OUT;
            end
            S_SCAN: begin
               if (phase_ff == PH_CENTRE) begin
                  kind_ff  <= PH_CENTRE;
                  tgt_r_ff <= la;
                  tgt_c_ff <= lo;
                  d_ff     <= lo - top.c1;
                  state_ff <= S_OFF;
               end else begin
                  phase_ff <= phase_ff + 3'd1;
                  if (!flags_ff[{scan_r, scan_c}]) begin
                     kind_ff  <= phase_ff;
                     tgt_r_ff <= scan_r;
                     tgt_c_ff <= scan_c;
                     d_ff     <= scan_d;
                     state_ff <= S_OFF;
                  end
               end
            end
            S_OFF: begin
               off_ff   <= off_c;
               sum_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= S_READ;
            end
            S_READ: begin
               // read data is registered, so it belongs to the address of the previous cycle
               if (cnt_ff != '0) begin
                  sum_ff <= sum_ff + V_W'(signed'(ram_rdata));
               end
               if (cnt_ff == RD_CNT_W'(1)) begin
                  ha_ff <= ram_rdata;
               end
               if (cnt_ff == n_reads) begin
                  state_ff <= S_AVG;
               end else begin
                  cnt_ff <= cnt_ff + RD_CNT_W'(1);
               end
            end
            S_AVG: begin
               v_ff     <= v_c;
               neg_ff   <= diff[V_W-1];
               state_ff <= skew ? S_SKEW : S_WRITE;
            end
            S_SKEW: begin
               if (div_sts.done) begin
                  v_ff     <= neg_ff ? v_ff - qs : v_ff + qs;
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               flags_ff[{tgt_r_ff, tgt_c_ff}] <= 1'b1;
               res_row_ff  <= COORD_OUT_W'(tgt_r_ff);
               res_col_ff  <= COORD_OUT_W'(tgt_c_ff);
               res_h_ff    <= sat_v;
               res_done_ff <= 1'b0;
               state_ff    <= (kind_ff == PH_CENTRE) ? S_ADV : S_OUT;
            end
            S_ADV: begin
               if (!leaf && depth_ff < SD_W'(STACK_DEPTH)) begin
                  push_k_ff <= CHILD_TL;
                  state_ff  <= S_PMUL;
               end else begin
                  depth_ff <= depth_m1;
                  state_ff <= S_POP;
               end
            end
            S_POP: begin
               if (depth_ff == '0) begin
                  // generation complete: start over at the first corner
                  res_done_ff <= 1'b1;
                  flags_ff    <= '0;
                  corner_ff   <= '0;
                  phase_ff    <= PH_TOP;
                  state_ff    <= S_OUT;
               end else if (top.child != CHILD_BR) begin
                  push_k_ff <= top.child + 2'd1;
                  state_ff  <= S_PMUL;
               end else begin
                  depth_ff <= depth_m1;
               end
            end
            S_PMUL: begin
               num_ff   <= top.variance * part;
               den_ff   <= span * dec_eff;
               state_ff <= S_PDIV;
            end
            S_PDIV: begin
               state_ff <= S_PWAIT;
            end
            S_PWAIT: begin
               if (div_sts.done) begin
                  stack_ff[depth_m1[IDX_W-1:0]].child <= push_k_ff;
                  stack_ff[depth_ff[IDX_W-1:0]] <= '{c1: child_f.c1, c2: child_f.c2,
                     c3: child_f.c3, c4: child_f.c4,
                     variance: (|div_quo[DIV_W-1:VAR_W]) ? '1 : div_quo[VAR_W-1:0],
                     child: CHILD_TL};
                  depth_ff <= depth_ff + SD_W'(1);
                  phase_ff <= PH_TOP;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.cell_row    = out_row_ff;
   assign rsp.cell_col    = out_col_ff;
   assign rsp.cell_height = out_h_ff;
   assign rsp.done_res    = out_done_ff;

   `ASSERT_IMP(a_depth_bound, clock, reset, 1'b1, depth_ff <= SD_W'(STACK_DEPTH))
   `ASSERT_IMP(a_corner_no_stack, clock, reset, corner_ff < 3'd4, depth_ff == '0)
   `ASSERT_IMP(a_div_idle_on_start, clock, reset, div_start, !div_sts.busy)
   `ASSERT_NXT(a_result_posted, clock, reset, state_ff == S_OUT && out_free, rsp_valid_ff)
endmodule
`default_nettype wire
